/* hw/rtl/lct_pkg.sv */
// lct_pkg: shared constants, command codes and transaction structs
// for the lru cache table unit; no dependencies
package lct_pkg;

  localparam int Entries  = 8;
  localparam int IdxW     = $clog2(Entries);
  localparam int RankW    = $clog2(Entries);
  localparam int CntW     = $clog2(Entries + 1);
  localparam int KeyW     = 32;
  localparam int DataW    = 32;
  localparam int CapW     = 4;
  localparam logic [CapW-1:0] CapReset = CapW'(3);

  typedef enum logic {
    CmdGet = 1'b0,
    CmdPut = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                    command;
    logic signed [KeyW-1:0]  key;
    logic        [DataW-1:0] write_value;
  } req_t;

  typedef struct packed {
    logic                    found;
    logic        [DataW-1:0] read_value;
    logic                    evicted;
    logic signed [KeyW-1:0]  evicted_key;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;     // capture request
    logic compare;  // search the table, register match and victim
    logic update;   // apply the access, register the response
    logic clear;    // capacity write: empty the store
  } ctl_t;

endpackage

/* hw/rtl/lru_cache_table_unit.sv */
// lru_cache_table_unit: top level of the fully associative lru key-value store
// depends on lct_pkg, lct_controller and lct_datapath
//
//   channel    signals                         direction  handshake
//   request    start_i, req_i                  in         start_i high, busy_o low
//   result     done_o, rsp_o                   out        one-cycle strobe, no stall
//   config     cfg_valid_i, cfg_data_i         in         cfg_valid_i and cfg_ready_o
//              cfg_ready_o                     out
//
// each transaction steps through accept, compare and update; the result
// strobe comes in the cycle after update, while the next request may already
// be accepted; busy_o holds off a new request through compare and update,
// and the compare stage is registered ahead of the rank update
// reset empties the table and sets capacity to three; a capacity write also
// empties the table and is taken only while idle with start_i low
// the result receiver cannot stall: rsp_o is valid only while done_o is high
module lru_cache_table_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request channel
  input  logic                              start_i,
  input  lct_pkg::req_t                     req_i,
  output logic                              busy_o,
  // result channel
  output logic                              done_o,
  output lct_pkg::rsp_t                     rsp_o,
  // capacity register write
  input  logic                              cfg_valid_i,
  input  logic          [lct_pkg::CapW-1:0] cfg_data_i,
  output logic                              cfg_ready_o
);

  // commands from the sequencer into the table datapath
  lct_pkg::ctl_t ctl;

  // sequencer: idle, compare, update; also gates config writes
  lct_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .cfg_valid_i (cfg_valid_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .cfg_ready_o (cfg_ready_o),
    .ctl_o       (ctl)
  );

  // entry table with parallel key match, victim select and rank aging
  lct_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .req_i      (req_i),
    .cfg_data_i (cfg_data_i),
    .rsp_o      (rsp_o)
  );

endmodule

/* hw/rtl/lct_datapath.sv */
// lct_datapath: entry table, parallel key compare, recency ranks and
// response register; depends on lct_pkg
module lct_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lct_pkg::ctl_t                       ctl_i,
  input  lct_pkg::req_t                       req_i,
  input  logic          [lct_pkg::CapW-1:0]   cfg_data_i,
  output lct_pkg::rsp_t                       rsp_o
);

  localparam int N = lct_pkg::Entries;

  // table state
  logic [N-1:0]                    valid_q;
  logic [lct_pkg::KeyW-1:0]        key_q  [N];
  logic [lct_pkg::DataW-1:0]       data_q [N];
  logic [lct_pkg::RankW-1:0]       rank_q [N];
  logic [lct_pkg::CntW-1:0]        used_q;
  logic [lct_pkg::CapW-1:0]        cap_q;

  // request and compare results
  lct_pkg::req_t                   req_q;
  logic                            hit_q;
  logic [lct_pkg::IdxW-1:0]        hit_idx_q;
  logic [lct_pkg::RankW-1:0]       hit_rank_q;
  logic [lct_pkg::DataW-1:0]       hit_data_q;
  logic [lct_pkg::IdxW-1:0]        slot_q;
  logic                            evict_q;
  logic [lct_pkg::KeyW-1:0]        evict_key_q;
  lct_pkg::rsp_t                   rsp_q;

  // compare stage logic
  logic [N-1:0]                    hit_vec;
  logic [N-1:0]                    victim_vec;
  logic                            hit_any;
  logic [lct_pkg::IdxW-1:0]        hit_idx;
  logic [lct_pkg::RankW-1:0]       hit_rank;
  logic [lct_pkg::DataW-1:0]       hit_data;
  logic [lct_pkg::IdxW-1:0]        free_idx;
  logic [lct_pkg::IdxW-1:0]        victim_idx;
  logic [lct_pkg::KeyW-1:0]        victim_key;
  logic [lct_pkg::CntW-1:0]        eff_cap;
  logic                            full;

  always_comb begin
    if (cap_q == '0) begin
      eff_cap = lct_pkg::CntW'(1);
    end else if (int'(cap_q) > N) begin
      eff_cap = lct_pkg::CntW'(N);
    end else begin
      eff_cap = lct_pkg::CntW'(cap_q);
    end
    full = (used_q >= eff_cap);
  end

  // keys are unique among valid entries and ranks are distinct, so the
  // match and the victim are at most one-hot
  always_comb begin
    hit_rank   = '0;
    hit_data   = '0;
    victim_key = '0;
    hit_idx    = '0;
    victim_idx = '0;
    free_idx   = '0;
    for (int i = 0; i < N; i++) begin
      hit_vec[i]    = valid_q[i] && (key_q[i] == req_q.key);
      victim_vec[i] = valid_q[i] &&
                      (lct_pkg::CntW'(rank_q[i]) == used_q - lct_pkg::CntW'(1));
      if (hit_vec[i]) begin
        hit_idx  = lct_pkg::IdxW'(i);
        hit_rank = hit_rank | rank_q[i];
        hit_data = hit_data | data_q[i];
      end
      if (victim_vec[i]) begin
        victim_idx = lct_pkg::IdxW'(i);
        victim_key = victim_key | key_q[i];
      end
    end
    // lowest free slot wins
    for (int i = N - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = lct_pkg::IdxW'(i);
      end
    end
    hit_any = |hit_vec;
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      req_q <= req_i;
    end
    if (ctl_i.compare) begin
      hit_q       <= hit_any;
      hit_idx_q   <= hit_idx;
      hit_rank_q  <= hit_rank;
      hit_data_q  <= hit_data;
      slot_q      <= full ? victim_idx : free_idx;
      evict_q     <= !hit_any && (req_q.command == lct_pkg::CmdPut) && full;
      evict_key_q <= victim_key;
    end
    if (ctl_i.update) begin
      rsp_q.found       <= hit_q;
      rsp_q.read_value  <= (hit_q && req_q.command == lct_pkg::CmdGet) ? hit_data_q : '0;
      rsp_q.evicted     <= evict_q;
      rsp_q.evicted_key <= evict_q ? evict_key_q : '0;
      if (req_q.command == lct_pkg::CmdPut) begin
        if (hit_q) begin
          data_q[hit_idx_q] <= req_q.write_value;
        end else begin
          data_q[slot_q] <= req_q.write_value;
          key_q[slot_q]  <= req_q.key;
        end
      end
    end
  end

  // table control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      used_q  <= '0;
      cap_q   <= lct_pkg::CapReset;
      for (int i = 0; i < N; i++) begin
        rank_q[i] <= '0;
      end
    end else if (ctl_i.clear) begin
      valid_q <= '0;
      used_q  <= '0;
      cap_q   <= cfg_data_i;
      for (int i = 0; i < N; i++) begin
        rank_q[i] <= '0;
      end
    end else if (ctl_i.update) begin
      if (hit_q) begin
        // promote: entries more recent than the hit age by one
        for (int i = 0; i < N; i++) begin
          if (valid_q[i] && lct_pkg::IdxW'(i) != hit_idx_q && rank_q[i] < hit_rank_q) begin
            rank_q[i] <= rank_q[i] + lct_pkg::RankW'(1);
          end
        end
        rank_q[hit_idx_q] <= '0;
      end else if (req_q.command == lct_pkg::CmdPut) begin
        // new entry: everyone else ages, victim or free slot takes it
        for (int i = 0; i < N; i++) begin
          if (valid_q[i] && lct_pkg::IdxW'(i) != slot_q) begin
            rank_q[i] <= rank_q[i] + lct_pkg::RankW'(1);
          end
        end
        rank_q[slot_q]  <= '0;
        valid_q[slot_q] <= 1'b1;
        if (!evict_q) begin
          used_q <= used_q + lct_pkg::CntW'(1);
        end
      end
    end
  end

  assign rsp_o = rsp_q;

endmodule

/* hw/rtl/lct_controller.sv */
// lct_controller: sequencer for accept, compare, update and result strobe;
// depends on lct_pkg
module lct_controller (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          cfg_valid_i,
  output logic          busy_o,
  output logic          done_o,
  output logic          cfg_ready_o,
  output lct_pkg::ctl_t ctl_o
);

  typedef enum logic [1:0] {
    StIdle,
    StCompare,
    StUpdate
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  assign busy_o      = (state_q != StIdle);
  assign cfg_ready_o = (state_q == StIdle) && !start_i;

  always_comb begin
    ctl_o         = '0;
    ctl_o.load    = (state_q == StIdle) && start_i;
    ctl_o.compare = (state_q == StCompare);
    ctl_o.update  = (state_q == StUpdate);
    ctl_o.clear   = cfg_valid_i && cfg_ready_o;
    case (state_q)
      StIdle:    state_d = start_i ? StCompare : StIdle;
      StCompare: state_d = StUpdate;
      StUpdate:  state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == StUpdate);
    end
  end

  assign done_o = done_q;

endmodule

/* tb/sv/lru_cache_table_unit_tb.sv */
// lru_cache_table_unit_tb: self-checking testbench for the lru cache table unit
// depends on lct_pkg and lru_cache_table_unit; runs a directed table, then random phases
// every result is checked against an internal lru shadow of the table or a typed row result
`timescale 1ns / 100ps

module lru_cache_table_unit_tb;

  localparam int             NumPhases     = 12;
  localparam int             ItemsPerPhase = 150;
  localparam int             DrainCycles   = 6;     // settle time before a capacity write
  localparam int             TailCycles    = 8;     // quiet time after the last result
  localparam int unsigned    IdleLimit     = 4000;  // cycles without any transaction
  localparam lct_pkg::rsp_t  RspNone       = '0;

  // capacity per random phase, extremes and out-of-range codes included
  localparam logic [lct_pkg::CapW-1:0] PhaseCap [NumPhases] = '{
    4'd1, 4'd8, 4'd4, 4'd0, 4'd15, 4'd2, 4'd9, 4'd6, 4'd3, 4'd7, 4'd5, 4'd12
  };
  // sender idle percentage, cycled over the phases
  localparam int unsigned PhaseIdle [4] = '{0, 55, 0, 14};

  typedef enum logic {
    RowAccess,
    RowCapacity
  } row_kind_e;

  typedef struct {
    row_kind_e                  kind;
    lct_pkg::req_t              req;
    logic [lct_pkg::CapW-1:0]   cap;
    bit                         typed;  // expected result written in the row itself
    lct_pkg::rsp_t              rsp;
  } dir_row_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       start_i;
  lct_pkg::req_t              req_i;
  logic                       busy_o;
  logic                       done_o;
  lct_pkg::rsp_t              rsp_o;
  logic                       cfg_valid_i;
  logic [lct_pkg::CapW-1:0]   cfg_data_i;
  logic                       cfg_ready_o;

  // shadow copy of the table and the capacity register
  logic                        shadow_valid [lct_pkg::Entries];
  logic [lct_pkg::KeyW-1:0]    shadow_key   [lct_pkg::Entries];
  logic [lct_pkg::DataW-1:0]   shadow_data  [lct_pkg::Entries];
  logic [lct_pkg::RankW-1:0]   shadow_rank  [lct_pkg::Entries];
  int unsigned                 shadow_used;
  logic [lct_pkg::CapW-1:0]    shadow_cap;

  lct_pkg::rsp_t pending_rsp [$];
  dir_row_t      dir_rows [$];
  int unsigned   fail_count = 0;
  int unsigned   quiet_cycles = 0;

  lru_cache_table_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // capacity zero acts as one, anything above the table size acts as full size
  function automatic int unsigned eff_capacity(input logic [lct_pkg::CapW-1:0] cap);
    if (cap == '0) return 1;
    if (cap > lct_pkg::Entries) return lct_pkg::Entries;
    return cap;
  endfunction

  function automatic void clear_shadow();
    for (int i = 0; i < lct_pkg::Entries; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_key[i]   = '0;
      shadow_data[i]  = '0;
      shadow_rank[i]  = '0;
    end
    shadow_used = 0;
  endfunction

  // applies one access to the shadow table and returns the result it causes
  function automatic lct_pkg::rsp_t lru_access(input lct_pkg::req_t r);
    lct_pkg::rsp_t             res;
    int                        hit;
    int                        slot;
    logic [lct_pkg::RankW-1:0] cur;
    logic [lct_pkg::RankW-1:0] worst;
    res = '0;
    hit = -1;
    for (int i = 0; i < lct_pkg::Entries; i++)
      if (hit < 0 && shadow_valid[i] && shadow_key[i] == r.key) hit = i;
    if (hit >= 0) begin
      // get hit or put replace: promote, entries more recent than it age by one
      res.found = 1'b1;
      if (r.command == lct_pkg::CmdGet) res.read_value = shadow_data[hit];
      else shadow_data[hit] = r.write_value;
      cur = shadow_rank[hit];
      for (int i = 0; i < lct_pkg::Entries; i++)
        if (shadow_valid[i] && i != hit && shadow_rank[i] < cur) shadow_rank[i]++;
      shadow_rank[hit] = '0;
    end else if (r.command == lct_pkg::CmdPut) begin
      slot = -1;
      if (shadow_used < eff_capacity(shadow_cap))
        for (int i = 0; i < lct_pkg::Entries; i++)
          if (slot < 0 && !shadow_valid[i]) slot = i;
      if (slot >= 0) begin
        for (int i = 0; i < lct_pkg::Entries; i++)
          if (shadow_valid[i]) shadow_rank[i]++;
        shadow_used++;
      end else begin
        // table full: the least recent entry gives up its slot
        worst = '0;
        slot  = 0;
        for (int i = 0; i < lct_pkg::Entries; i++)
          if (shadow_valid[i] && shadow_rank[i] >= worst) begin
            worst = shadow_rank[i];
            slot  = i;
          end
        res.evicted     = 1'b1;
        res.evicted_key = shadow_key[slot];
        for (int i = 0; i < lct_pkg::Entries; i++)
          if (shadow_valid[i] && i != slot) shadow_rank[i]++;
      end
      shadow_valid[slot] = 1'b1;
      shadow_key[slot]   = r.key;
      shadow_data[slot]  = r.write_value;
      shadow_rank[slot]  = '0;
    end
    return res;
  endfunction

  function automatic dir_row_t access_row(input lct_pkg::cmd_e c,
                                          input logic [lct_pkg::KeyW-1:0] k,
                                          input logic [lct_pkg::DataW-1:0] v,
                                          input bit typed = 1'b0,
                                          input lct_pkg::rsp_t r = '0);
    dir_row_t row;
    row.kind  = RowAccess;
    row.req   = '{command: c, key: k, write_value: v};
    row.cap   = '0;
    row.typed = typed;
    row.rsp   = r;
    return row;
  endfunction

  function automatic dir_row_t capacity_row(input logic [lct_pkg::CapW-1:0] cap);
    dir_row_t row;
    row.kind  = RowCapacity;
    row.req   = '0;
    row.cap   = cap;
    row.typed = 1'b0;
    row.rsp   = RspNone;
    return row;
  endfunction

  // offers one request transaction, with a random idle gap ahead of it
  task automatic issue_req(input lct_pkg::req_t r, input int unsigned idle_pct,
                           input bit typed, input lct_pkg::rsp_t typed_rsp);
    lct_pkg::rsp_t pred;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
    pred = lru_access(r);
    pending_rsp.push_back(typed ? typed_rsp : pred);
  endtask

  // capacity write only once the unit has gone quiet
  task automatic write_capacity(input logic [lct_pkg::CapW-1:0] value);
    start_i <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    shadow_cap = value;
    clear_shadow();
  endtask

  // result checker: every strobe is matched against the oldest expectation
  always @(posedge clk_i) begin : result_check
    lct_pkg::rsp_t exp_rsp;
    if (rst_ni && done_o) begin
      if (pending_rsp.size() == 0) begin
        $error("result transaction with no expectation pending");
        fail_count++;
      end else begin
        exp_rsp = pending_rsp.pop_front();
        if (rsp_o.found !== exp_rsp.found) begin
          $error("found: expected %0d, actual %0d", exp_rsp.found, rsp_o.found);
          fail_count++;
        end
        if (rsp_o.read_value !== exp_rsp.read_value) begin
          $error("read_value: expected %h, actual %h", exp_rsp.read_value, rsp_o.read_value);
          fail_count++;
        end
        if (rsp_o.evicted !== exp_rsp.evicted) begin
          $error("evicted: expected %0d, actual %0d", exp_rsp.evicted, rsp_o.evicted);
          fail_count++;
        end
        if (rsp_o.evicted_key !== exp_rsp.evicted_key) begin
          $error("evicted_key: expected %h, actual %h", exp_rsp.evicted_key,
                 rsp_o.evicted_key);
          fail_count++;
        end
      end
    end
  end

  // watchdog: any request, result or capacity transaction resets the count
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IdleLimit) begin
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    lct_pkg::req_t            r;
    logic [lct_pkg::KeyW-1:0] key_pool [lct_pkg::Entries + 3];
    int unsigned              pool_size;
    int unsigned              idle_pct;

    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    req_i       <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    shadow_cap  = lct_pkg::CapReset;
    clear_shadow();

    // directed table, reset capacity of three first
    dir_rows.push_back(access_row(lct_pkg::CmdGet, 32'h0000_0000, 32'hffff_ffff, 1'b1,
                                  RspNone));
    dir_rows.push_back(access_row(lct_pkg::CmdPut, 32'h7fff_ffff, 32'hffff_ffff, 1'b1,
                                  RspNone));
    dir_rows.push_back(access_row(lct_pkg::CmdPut, 32'h8000_0000, 32'h0000_0000, 1'b1,
                                  RspNone));
    dir_rows.push_back(access_row(lct_pkg::CmdGet, 32'h7fff_ffff, 32'h0000_0000, 1'b1,
                                  lct_pkg::rsp_t'{1'b1, 32'hffff_ffff, 1'b0, 32'sd0}));
    dir_rows.push_back(access_row(lct_pkg::CmdPut, 32'h0000_0000, 32'h0000_1234, 1'b1,
                                  RspNone));
    // table full: the least recently used key goes
    dir_rows.push_back(access_row(lct_pkg::CmdPut, 32'hffff_ffff, 32'ha5a5_a5a5, 1'b1,
                                  lct_pkg::rsp_t'{1'b0, 32'h0, 1'b1, 32'sh8000_0000}));
    // put of a present key replaces, no eviction
    dir_rows.push_back(access_row(lct_pkg::CmdPut, 32'h0000_0000, 32'h0000_0005, 1'b1,
                                  lct_pkg::rsp_t'{1'b1, 32'h0, 1'b0, 32'sd0}));
    dir_rows.push_back(access_row(lct_pkg::CmdGet, 32'h8000_0000, 32'h0, 1'b1, RspNone));
    dir_rows.push_back(access_row(lct_pkg::CmdGet, 32'hffff_ffff, 32'h0));
    dir_rows.push_back(access_row(lct_pkg::CmdGet, 32'h0000_0000, 32'h0));
    // capacity zero keeps a single entry
    dir_rows.push_back(capacity_row(4'd0));
    dir_rows.push_back(access_row(lct_pkg::CmdPut, 32'd5, 32'd1, 1'b1, RspNone));
    dir_rows.push_back(access_row(lct_pkg::CmdPut, 32'd6, 32'd2, 1'b1,
                                  lct_pkg::rsp_t'{1'b0, 32'h0, 1'b1, 32'sd5}));
    dir_rows.push_back(access_row(lct_pkg::CmdGet, 32'd5, 32'h0, 1'b1, RspNone));
    dir_rows.push_back(access_row(lct_pkg::CmdGet, 32'd6, 32'h0, 1'b1,
                                  lct_pkg::rsp_t'{1'b1, 32'd2, 1'b0, 32'sd0}));
    // capacity above the table size saturates
    dir_rows.push_back(capacity_row(4'd15));
    for (int k = 0; k <= lct_pkg::Entries; k++)
      dir_rows.push_back(access_row(lct_pkg::CmdPut, 32'd100 + k, 32'hc000_0000 + k));
    dir_rows.push_back(access_row(lct_pkg::CmdGet, 32'd101, 32'h0));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[n]) begin
      if (dir_rows[n].kind == RowCapacity) begin
        write_capacity(dir_rows[n].cap);
      end else begin
        issue_req(dir_rows[n].req, 0, dir_rows[n].typed, dir_rows[n].rsp);
      end
    end

    // random phases: keys mostly from a small pool so hits and evictions are common
    for (int ph = 0; ph < NumPhases; ph++) begin
      write_capacity(PhaseCap[ph]);
      idle_pct  = PhaseIdle[ph % 4];
      pool_size = eff_capacity(PhaseCap[ph]) + 3;
      for (int k = 0; k < pool_size; k++) key_pool[k] = $urandom;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        r.command     = $urandom_range(1) ? lct_pkg::CmdPut : lct_pkg::CmdGet;
        r.key         = ($urandom_range(9) == 0) ? $urandom
                                                 : key_pool[$urandom_range(pool_size - 1)];
        r.write_value = $urandom;
        issue_req(r, idle_pct, 1'b0, RspNone);
      end
    end

    start_i <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
